// ===== sv/jsu_pkg.sv =====
// jsu_pkg: shared types, character constants and helper functions for the
// json string unescape core. No dependencies.
package jsu_pkg;

  localparam int unsigned MaxOut = 5;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQmark  = 8'h3F;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] Utf8Two  = 8'hC0;
  localparam logic [7:0] Utf8Cont = 8'h80;
  localparam logic [7:0] Utf8Three = 8'hE0;
  localparam logic [5:0] Low6Mask = 6'h3F;
  localparam logic [15:0] TwoByteLimit = 16'h0800;
  localparam logic [15:0] OneByteLimit = 16'h0080;

  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_ESCAPE = 2'd1,
    PH_HEX    = 2'd2
  } phase_t;

  // decoder state with reset; raw digit bytes live outside, without reset
  typedef struct packed {
    phase_t      phase;
    logic [1:0]  taken;
    logic [11:0] cp;
  } dec_state_t;

  // one group of result words caused by a single input word
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             cnt;
  } grp_t;

  // {valid, value} of an ascii hex digit, either case
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  // simple single-character escapes; anything else passes as itself
  function automatic logic [7:0] escape_map(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    unique case (b)
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      default: r = b;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/jsu_if.sv =====
// jsu_in_if / jsu_out_if: valid/ready channels for raw and decoded words.
// No dependencies.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       string_end;

  modport source (output valid, output in_byte, output string_end, input ready);
  modport sink   (input valid, input in_byte, input string_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_last;

  modport source (output valid, output out_byte, output run_last, output string_last,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input string_last,
                  output ready);
endinterface

// ===== sv/jsu_decode.sv =====
// jsu_decode: combinational step of the unescape decoder, producing the
// next state and the group of up to five result words. Depends on jsu_pkg.
module jsu_decode (
  input  jsu_pkg::dec_state_t  st,
  input  logic [2:0][7:0]      pend,
  input  logic [7:0]           in_byte,
  input  logic                 string_end,
  output jsu_pkg::dec_state_t  st_nxt,
  output logic                 pend_we,
  output jsu_pkg::grp_t        grp
);

  logic [4:0]  hv;
  logic [15:0] cp_full;
  logic [jsu_pkg::MaxOut-1:0][7:0] abort_list;
  logic        opens_escape;

  assign hv = jsu_pkg::hex_value(in_byte);
  assign cp_full = {st.cp, hv[3:0]};
  assign opens_escape = (in_byte == jsu_pkg::ChBslash) && !string_end;

  // '?' then the taken digits, with the current byte right after them
  always_comb begin
    abort_list[0] = jsu_pkg::ChQmark;
    for (int k = 0; k < 3; k++) begin
      abort_list[k+1] = (2'(k) < st.taken) ? pend[k] : in_byte;
    end
    abort_list[4] = in_byte;
  end

  always_comb begin
    st_nxt    = st;
    pend_we   = 1'b0;
    grp.bytes = '0;
    grp.cnt   = 3'd0;
    unique case (st.phase)
      jsu_pkg::PH_ESCAPE: begin
        st_nxt.phase = jsu_pkg::PH_NORMAL;
        grp.cnt      = 3'd1;
        if (in_byte == jsu_pkg::ChU) begin
          if (string_end) begin
            grp.bytes[0] = jsu_pkg::ChQmark;
          end else begin
            st_nxt.phase = jsu_pkg::PH_HEX;
            st_nxt.taken = 2'd0;
            st_nxt.cp    = 12'd0;
            grp.cnt      = 3'd0;
          end
        end else begin
          grp.bytes[0] = jsu_pkg::escape_map(in_byte);
        end
      end
      jsu_pkg::PH_HEX: begin
        if (!hv[4]) begin
          // bad digit: replay, then treat this byte as a plain one, or as a new escape if it is a backslash
          grp.bytes    = abort_list;
          grp.cnt      = 3'd1 + 3'(st.taken) + (opens_escape ? 3'd0 : 3'd1);
          st_nxt.phase = opens_escape ? jsu_pkg::PH_ESCAPE : jsu_pkg::PH_NORMAL;
          st_nxt.taken = 2'd0;
          st_nxt.cp    = 12'd0;
        end else if (st.taken == 2'd3) begin
          st_nxt.phase = jsu_pkg::PH_NORMAL;
          st_nxt.taken = 2'd0;
          st_nxt.cp    = 12'd0;
          if (cp_full < jsu_pkg::OneByteLimit) begin
            grp.bytes[0] = cp_full[7:0];
            grp.cnt      = 3'd1;
          end else if (cp_full < jsu_pkg::TwoByteLimit) begin
            grp.bytes[0] = jsu_pkg::Utf8Two | {3'd0, cp_full[10:6]};
            grp.bytes[1] = jsu_pkg::Utf8Cont | {2'd0, cp_full[5:0] & jsu_pkg::Low6Mask};
            grp.cnt      = 3'd2;
          end else begin
            grp.bytes[0] = jsu_pkg::Utf8Three | {4'd0, cp_full[15:12]};
            grp.bytes[1] = jsu_pkg::Utf8Cont | {2'd0, cp_full[11:6]};
            grp.bytes[2] = jsu_pkg::Utf8Cont | {2'd0, cp_full[5:0] & jsu_pkg::Low6Mask};
            grp.cnt      = 3'd3;
          end
        end else begin
          pend_we      = 1'b1;
          st_nxt.taken = st.taken + 2'd1;
          st_nxt.cp    = cp_full[11:0];
          if (string_end) begin
            // string ended inside the escape: replay digits incl. this one
            grp.bytes = abort_list;
            grp.cnt   = 3'd2 + 3'(st.taken);
          end
        end
      end
      default: begin
        if (opens_escape) begin
          st_nxt.phase = jsu_pkg::PH_ESCAPE;
        end else begin
          grp.bytes[0] = in_byte;
          grp.cnt      = 3'd1;
        end
      end
    endcase
    if (string_end) begin
      st_nxt.phase = jsu_pkg::PH_NORMAL;
      st_nxt.taken = 2'd0;
      st_nxt.cp    = 12'd0;
    end
  end

endmodule

// ===== sv/json_string_unescape_core.sv =====
// json_string_unescape_core: streaming json string body unescaper.
// The first decoded word of an input word is offered the cycle after
// acceptance. Throughput: one input word per cycle while each yields at most
// one result and the output is ready; a word that yields n results (n is at
// most 5) holds the input while the register drains one word per ready cycle.
// Reset (synchronous, rst_n low) returns to the normal phase, no results held.
// Depends on jsu_pkg, jsu_in_if, jsu_out_if and jsu_decode.
module json_string_unescape_core (
  input  logic        clk,
  input  logic        rst_n,
  jsu_in_if.sink      in_ch,
  jsu_out_if.source   out_ch
);

  jsu_pkg::dec_state_t st_r, st_nxt;
  logic [7:0]          pend_r [3];
  logic [2:0][7:0]     pend_flat;
  logic                pend_we;
  jsu_pkg::grp_t       grp_nxt;

  logic [jsu_pkg::MaxOut-1:0][7:0] bytes_r;
  logic [2:0]          cnt_r;
  logic                end_r;

  logic in_fire;
  logic out_fire;

  assign pend_flat = {pend_r[2], pend_r[1], pend_r[0]};

  jsu_decode u_decode (
    .st         (st_r),
    .pend       (pend_flat),
    .in_byte    (in_ch.in_byte),
    .string_end (in_ch.string_end),
    .st_nxt     (st_nxt),
    .pend_we    (pend_we),
    .grp        (grp_nxt)
  );

  // take a new word when the result register is empty or its last word leaves now
  assign in_ch.ready = (cnt_r == 3'd0) || (out_ch.ready && cnt_r == 3'd1);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_fire    = out_ch.valid && out_ch.ready;

  assign out_ch.valid       = (cnt_r != 3'd0);
  assign out_ch.out_byte    = bytes_r[0];
  assign out_ch.run_last    = (cnt_r == 3'd1);
  assign out_ch.string_last = (cnt_r == 3'd1) && end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= jsu_pkg::PH_NORMAL;
      st_r.taken <= 2'd0;
      st_r.cp    <= 12'd0;
      cnt_r      <= 3'd0;
    end else begin
      if (in_fire) begin
        st_r  <= st_nxt;
        cnt_r <= grp_nxt.cnt;
      end else if (out_fire) begin
        cnt_r <= cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      bytes_r <= grp_nxt.bytes;
      end_r   <= in_ch.string_end;
      if (pend_we) begin
        pend_r[st_r.taken] <= in_ch.in_byte;
      end
    end else if (out_fire) begin
      // shift the next word to the head
      bytes_r <= {8'd0, bytes_r[jsu_pkg::MaxOut-1:1]};
    end
  end

endmodule
